>>> hdl/sfla_pkg.sv
`timescale 1ns / 1ps

package sfla_pkg;

  // Input transaction: one push or pop request
  typedef struct packed {
    logic        req_type;
    logic [31:0] request_size;
    logic [39:0] free_value;
  } req_t;

  // Output transaction: one result per request
  typedef struct packed {
    logic [2:0]  status;
    logic [34:0] granted_size;
    logic [39:0] popped_value;
  } rsp_t;

  typedef enum logic [2:0] {
    ST_PUSHED = 3'd0,
    ST_POPPED = 3'd1,
    ST_NONE   = 3'd2,
    ST_RANGE  = 3'd3,
    ST_NOPAGE = 3'd4
  } status_e;

  localparam logic REQ_PUSH = 1'b0;
  localparam logic REQ_POP  = 1'b1;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic    capture;
    logic    dir_rd_push;
    logic    dir_rd_scan;
    logic    pg_rd_tgt;
    logic    push_write;
    logic    pg_rd_scan;
    logic    pop_take;
    logic    scan_init;
    logic    scan_inc;
    logic    out_load;
    status_e out_code;
  } cmd_t;

  // Status flags from the datapath to the controller
  typedef struct packed {
    logic range_bad;
    logic req_pop;
    logic first_nopage;
    logic push_nopage;
    logic scan_end;
    logic dir_empty;
    logic cnt_zero;
    logic out_free;
  } sts_t;

endpackage

>>> hdl/sfla_ctrl.sv
`timescale 1ns / 1ps

module sfla_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_ready,
  input  sfla_pkg::sts_t  sts,
  output sfla_pkg::cmd_t  cmd
);
  import sfla_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_DECODE = 9'b000000010,
    S_P_DIR  = 9'b000000100,
    S_P_PAGE = 9'b000001000,
    S_CHK    = 9'b000010000,
    S_S_DIR  = 9'b000100000,
    S_S_CNT  = 9'b001000000,
    S_S_SLOT = 9'b010000000,
    S_DONE   = 9'b100000000
  } state_t;

  state_t  state, state_next;
  status_e code, code_next;

  // Sequence one request through the datapath
  always_comb begin
    state_next = state;
    code_next  = code;
    cmd        = '0;
    cmd.out_code = code;
    req_ready  = 1'b0;
    case (state)
      S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_DECODE;
        end
      end
      S_DECODE: begin
        if (sts.range_bad) begin
          code_next  = ST_RANGE;
          state_next = S_DONE;
        end else if (!sts.req_pop) begin
          cmd.dir_rd_push = 1'b1;
          state_next      = S_P_DIR;
        end else begin
          cmd.scan_init = 1'b1;
          state_next    = S_CHK;
        end
      end
      S_P_DIR: begin
        if (sts.first_nopage) begin
          code_next  = ST_NOPAGE;
          state_next = S_DONE;
        end else begin
          cmd.pg_rd_tgt = 1'b1;
          state_next    = S_P_PAGE;
        end
      end
      S_P_PAGE: begin
        if (sts.push_nopage) begin
          code_next = ST_NOPAGE;
        end else begin
          cmd.push_write = 1'b1;
          code_next      = ST_PUSHED;
        end
        state_next = S_DONE;
      end
      S_CHK: begin
        if (sts.scan_end) begin
          code_next  = ST_NONE;
          state_next = S_DONE;
        end else begin
          cmd.dir_rd_scan = 1'b1;
          state_next      = S_S_DIR;
        end
      end
      S_S_DIR: begin
        if (sts.dir_empty) begin
          cmd.scan_inc = 1'b1;
          state_next   = S_CHK;
        end else begin
          cmd.pg_rd_scan = 1'b1;
          state_next     = S_S_CNT;
        end
      end
      S_S_CNT: begin
        if (sts.cnt_zero) begin
          cmd.scan_inc = 1'b1;
          state_next   = S_CHK;
        end else begin
          cmd.pop_take = 1'b1;
          state_next   = S_S_SLOT;
        end
      end
      S_S_SLOT: begin
        code_next  = ST_POPPED;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      code  <= ST_NONE;
    end else begin
      state <= state_next;
      code  <= code_next;
    end
  end

endmodule

>>> hdl/sfla_dp.sv
`timescale 1ns / 1ps

module sfla_dp #(
  parameter int CLASS_COUNT       = 32,
  parameter int CLASS_LOG2_OFFSET = 3,
  parameter int ENTRIES_PER_PAGE  = 64,
  parameter int PAGE_COUNT        = 256,
  parameter int VALUE_BITS        = 40
) (
  input  logic           clk,
  input  logic           rst,
  input  sfla_pkg::req_t req,
  input  sfla_pkg::cmd_t cmd,
  output sfla_pkg::sts_t sts,
  input  logic           rsp_ready,
  output logic           rsp_valid,
  output sfla_pkg::rsp_t rsp
);
  import sfla_pkg::*;

  localparam int CLW   = $clog2(CLASS_COUNT);
  localparam int CIW   = $clog2(CLASS_COUNT + 1);
  localparam int PW    = $clog2(PAGE_COUNT);
  localparam int CNW   = $clog2(ENTRIES_PER_PAGE + 1);
  localparam int SLOTS = PAGE_COUNT * ENTRIES_PER_PAGE;
  localparam int SAW   = $clog2(SLOTS);
  localparam logic [PW:0]    PAGE_LIMIT = (PW + 1)'(PAGE_COUNT);
  localparam logic [CNW-1:0] EPP        = CNW'(ENTRIES_PER_PAGE);

  typedef struct packed {
    logic [PW-1:0] first;
    logic [PW-1:0] last;
  } dir_t;

  function automatic logic [SAW-1:0] slot_base(input logic [PW-1:0] p);
    return SAW'(p) * SAW'(ENTRIES_PER_PAGE);
  endfunction

  // Request and scan registers
  req_t           req_q;
  logic [CLW-1:0] cls_q;
  logic [CIW-1:0] idx;
  logic [CIW-1:0] ciu;
  logic [PW-1:0]  pa;
  logic [PW-1:0]  first_q, target_q, lp_q;

  // Class directory and page tables
  dir_t                   dir_mem [CLASS_COUNT];
  logic [CLASS_COUNT-1:0] dir_vld;
  dir_t                   dir_rd;
  logic                   dir_rd_vld;
  logic [CNW-1:0]         cnt_mem  [PAGE_COUNT];
  logic [PW-1:0]          prev_mem [PAGE_COUNT];
  logic [PW-1:0]          next_mem [PAGE_COUNT];
  logic [CNW-1:0]         cnt_rd;
  logic [PW-1:0]          prev_rd, next_rd;
  logic                   pg_rd_ok;
  logic [VALUE_BITS-1:0]  slot_mem [SLOTS];
  logic [VALUE_BITS-1:0]  slot_rd;

  // Decode signals
  logic [6:0]     lg, cls_raw;
  logic           size_ok;
  logic [CLW-1:0] cls;

  // Push and pop signals
  logic [PW-1:0]  dir_first, dir_last;
  logic [PW:0]    pa_inc, lp_inc;
  logic [PW-1:0]  tgt, first_n, lp_n;
  logic [CNW-1:0] pg_cnt;
  logic [PW-1:0]  pg_next, pg_prev;
  logic           full;
  logic [PW-1:0]  new_pg, lp_fin, push_last;
  logic [PW-1:0]  pg_raddr;
  logic [CLW-1:0] dir_raddr;
  logic [SAW-1:0] push_addr, pop_addr;
  logic [7:0]     sh;

  // Find the size class from the highest set bit
  always_comb begin
    lg = '0;
    for (int k = 0; k < 32; k++) begin
      if (req_q.request_size[k]) lg = 7'(k);
    end
  end

  assign cls_raw = lg - 7'(CLASS_LOG2_OFFSET);
  assign size_ok = (|req_q.request_size) && (lg >= 7'(CLASS_LOG2_OFFSET)) &&
                   (cls_raw < 7'(CLASS_COUNT));
  assign cls     = cls_raw[CLW-1:0];

  // Directory and page words, zero where never written
  assign dir_first = dir_rd_vld ? dir_rd.first : '0;
  assign dir_last  = dir_rd_vld ? dir_rd.last  : '0;
  assign pg_cnt    = pg_rd_ok ? cnt_rd  : '0;
  assign pg_next   = pg_rd_ok ? next_rd : '0;
  assign pg_prev   = pg_rd_ok ? prev_rd : '0;

  // Pick the target page of a push
  assign pa_inc = {1'b0, pa} + 1'b1;
  always_comb begin
    if (dir_first == '0) begin
      lp_n    = pa_inc[PW-1:0];
      first_n = pa_inc[PW-1:0];
      tgt     = pa_inc[PW-1:0];
    end else begin
      lp_n    = pa;
      first_n = dir_first;
      tgt     = (dir_last != '0) ? dir_last : dir_first;
    end
  end

  // Move to a chained or fresh page when the target is full
  assign full      = pg_cnt >= EPP;
  assign lp_inc    = {1'b0, lp_q} + 1'b1;
  assign new_pg    = (pg_next == '0) ? lp_inc[PW-1:0] : pg_next;
  assign lp_fin    = (full && pg_next == '0) ? lp_inc[PW-1:0] : lp_q;
  assign push_last = full ? new_pg : target_q;
  assign push_addr = full ? slot_base(new_pg) : slot_base(target_q) + SAW'(pg_cnt);
  assign pop_addr  = slot_base(target_q) + SAW'(pg_cnt) - 1'b1;

  assign pg_raddr  = cmd.pg_rd_tgt ? tgt : dir_last;
  assign dir_raddr = cmd.dir_rd_push ? cls : idx[CLW-1:0];

  assign sts.range_bad    = !size_ok;
  assign sts.req_pop      = req_q.req_type == REQ_POP;
  assign sts.first_nopage = (dir_first == '0) && (pa_inc >= PAGE_LIMIT);
  assign sts.push_nopage  = full && (pg_next == '0) && (lp_inc >= PAGE_LIMIT);
  assign sts.scan_end     = idx >= ciu;
  assign sts.dir_empty    = dir_last == '0;
  assign sts.cnt_zero     = pg_cnt == '0;
  assign sts.out_free     = !rsp_valid || rsp_ready;

  assign sh = 8'(idx) + 8'(CLASS_LOG2_OFFSET);

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      ciu       <= '0;
      pa        <= '0;
      dir_vld   <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (cmd.push_write) begin
        pa             <= lp_fin;
        dir_vld[cls_q] <= 1'b1;
        if (ciu < CIW'(cls_q) + 1'b1) ciu <= CIW'(cls_q) + 1'b1;
      end
      if (cmd.out_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Hold request, scan index and push bookkeeping
  always_ff @(posedge clk) begin
    if (cmd.capture) req_q <= req;
    if (cmd.dir_rd_push || cmd.scan_init) cls_q <= cls;
    if (cmd.scan_init) begin
      idx <= CIW'(cls);
    end else if (cmd.scan_inc) begin
      idx <= idx + 1'b1;
    end
    if (cmd.pg_rd_tgt) begin
      target_q <= tgt;
      first_q  <= first_n;
      lp_q     <= lp_n;
    end else if (cmd.pg_rd_scan) begin
      target_q <= dir_last;
    end
  end

  // Class directory memory
  always_ff @(posedge clk) begin
    if (cmd.dir_rd_push || cmd.dir_rd_scan) begin
      dir_rd     <= dir_mem[dir_raddr];
      dir_rd_vld <= dir_vld[dir_raddr];
    end
    if (cmd.push_write) begin
      dir_mem[cls_q] <= '{first: first_q, last: push_last};
    end else if (cmd.pop_take && pg_cnt == CNW'(1)) begin
      dir_mem[idx[CLW-1:0]] <= '{first: dir_rd.first, last: pg_prev};
    end
  end

  // Page tables; pages above the allocation mark read as zero
  always_ff @(posedge clk) begin
    if (cmd.pg_rd_tgt || cmd.pg_rd_scan) begin
      cnt_rd   <= cnt_mem[pg_raddr];
      prev_rd  <= prev_mem[pg_raddr];
      next_rd  <= next_mem[pg_raddr];
      pg_rd_ok <= pg_raddr <= pa;
    end
    if (cmd.push_write) begin
      if (full) begin
        cnt_mem[new_pg] <= CNW'(1);
      end else begin
        cnt_mem[target_q] <= pg_cnt + 1'b1;
      end
    end else if (cmd.pop_take) begin
      cnt_mem[target_q] <= pg_cnt - 1'b1;
    end
    // Clear the links of the page a push may take fresh
    if (cmd.pg_rd_tgt) begin
      prev_mem[pa_inc[PW-1:0]] <= '0;
    end else if (cmd.push_write && full) begin
      prev_mem[new_pg] <= target_q;
    end
    if (cmd.pg_rd_tgt) begin
      next_mem[pa_inc[PW-1:0]] <= '0;
    end else if (cmd.push_write && full && pg_next == '0) begin
      next_mem[target_q] <= new_pg;
    end
  end

  // Slot value memory
  always_ff @(posedge clk) begin
    if (cmd.push_write) slot_mem[push_addr] <= VALUE_BITS'(req_q.free_value);
    if (cmd.pop_take) slot_rd <= slot_mem[pop_addr];
  end

  // Output register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      rsp.status <= cmd.out_code;
      if (cmd.out_code == ST_POPPED) begin
        rsp.granted_size <= (sh < 8'd35) ? (35'd1 << sh) : '0;
        rsp.popped_value <= 40'(slot_rd);
      end else begin
        rsp.granted_size <= '0;
        rsp.popped_value <= '0;
      end
    end
  end

endmodule

>>> hdl/segregated_free_list_allocator.sv
`timescale 1ns / 1ps

// Channel | Signals                       | Transaction
// req     | req_valid, req_ready, req     | push or pop request
// rsp     | rsp_valid, rsp_ready, rsp     | one status result per request
//
// One request at a time; req_ready is high only while the controller is idle.
// A size out of range ends after decode; a push reads the class directory, then the
// target page, and writes nothing when no page is left; a pop scans the classes upward
// from the requested one and reads the directory and page of each until one holds a slot.
// A waiting result holds the next one in its last state, so req_ready stays low
// until rsp is taken. Reset is synchronous; page tables need no clearing pass.
module segregated_free_list_allocator #(
  parameter int CLASS_COUNT       = 32,
  parameter int CLASS_LOG2_OFFSET = 3,
  parameter int ENTRIES_PER_PAGE  = 64,
  parameter int PAGE_COUNT        = 256,
  parameter int VALUE_BITS        = 40
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_ready,
  input  sfla_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_ready,
  output sfla_pkg::rsp_t rsp
);
  import sfla_pkg::*;

  cmd_t cmd;
  sts_t sts;

  sfla_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  sfla_dp #(
    .CLASS_COUNT       (CLASS_COUNT),
    .CLASS_LOG2_OFFSET (CLASS_LOG2_OFFSET),
    .ENTRIES_PER_PAGE  (ENTRIES_PER_PAGE),
    .PAGE_COUNT        (PAGE_COUNT),
    .VALUE_BITS        (VALUE_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cmd       (cmd),
    .sts       (sts),
    .rsp_ready (rsp_ready),
    .rsp_valid (rsp_valid),
    .rsp       (rsp)
  );

endmodule

>>> hdl/sfla_checker.sv
`timescale 1ns / 1ps

module sfla_checker (
  input logic           clk,
  input logic           rst,
  input logic           req_valid,
  input logic           req_ready,
  input logic           rsp_valid,
  input logic           rsp_ready,
  input sfla_pkg::rsp_t rsp
);
  import sfla_pkg::*;

  // Hold a stalled result
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("result changed while stalled");

  // Only pops carry a size and a value
  a_zero_fields: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status != ST_POPPED |-> rsp.granted_size == '0 &&
    rsp.popped_value == '0)
    else $error("non-pop result carries data");

  // Granted size is a power of two or zero
  a_pow2: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status == ST_POPPED |-> $onehot0(rsp.granted_size))
    else $error("granted size not a power of two");

  // Take one request at a time
  a_one_req: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request accepted while busy");

  // No result right after reset
  a_reset: assert property (@(posedge clk)
    $past(rst) |-> !rsp_valid)
    else $error("result valid after reset");

endmodule

bind segregated_free_list_allocator sfla_checker u_sfla_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_ready (req_ready),
  .rsp_valid (rsp_valid),
  .rsp_ready (rsp_ready),
  .rsp       (rsp)
);

>>> dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import sfla_pkg::*;

  localparam int NCLS = 32;
  localparam int LOG2_OFF = 3;
  localparam int EPP = 64;
  localparam int NPG = 256;
  localparam longint CYCLE_LIMIT = 400000;

  // Allocator state mirror and queue of pending results
  class alloc_scoreboard;
    int unsigned cls_used;
    int unsigned pg_top;
    int unsigned first_pg[NCLS];
    int unsigned last_pg[NCLS];
    int unsigned pg_cnt[NPG];
    int unsigned pg_prev[NPG];
    int unsigned pg_next[NPG];
    logic [39:0] slot_mem[int unsigned];
    rsp_t pending_rsp[$];
    int errors;

    function void clear();
      cls_used = 0;
      pg_top = 0;
      foreach (first_pg[i]) begin
        first_pg[i] = 0;
        last_pg[i] = 0;
      end
      foreach (pg_cnt[i]) begin
        pg_cnt[i] = 0;
        pg_prev[i] = 0;
        pg_next[i] = 0;
      end
      slot_mem.delete();
      pending_rsp.delete();
      errors = 0;
    endfunction

    // Map size to class; return -1 when out of range
    function int size_to_class(logic [31:0] size);
      int lg;
      lg = -1;
      for (int b = 31; b >= 0; b--) begin
        if (size[b] && lg < 0) lg = b;
      end
      if (lg < LOG2_OFF) return -1;
      if (lg - LOG2_OFF >= NCLS) return -1;
      return lg - LOG2_OFF;
    endfunction

    function status_e push_slot(int unsigned c, logic [39:0] val);
      int unsigned first, last, top, tgt, cnt, nxt;
      first = first_pg[c];
      last = last_pg[c];
      top = pg_top;
      if (first == 0) begin
        if (top + 1 >= NPG) return ST_NOPAGE;
        top++;
        first = top;
        tgt = top;
      end else if (last == 0) begin
        tgt = first;
      end else begin
        tgt = last;
      end
      cnt = pg_cnt[tgt];
      if (cnt >= EPP) begin
        nxt = pg_next[tgt];
        if (nxt == 0) begin
          if (top + 1 >= NPG) return ST_NOPAGE;
          top++;
          nxt = top;
          pg_next[tgt] = nxt;
        end
        pg_cnt[nxt] = 1;
        pg_prev[nxt] = tgt;
        slot_mem[nxt * EPP] = val;
        last = nxt;
      end else begin
        slot_mem[tgt * EPP + cnt] = val;
        pg_cnt[tgt] = cnt + 1;
        last = tgt;
      end
      first_pg[c] = first;
      last_pg[c] = last;
      pg_top = top;
      if (cls_used < c + 1) cls_used = c + 1;
      return ST_PUSHED;
    endfunction

    // Note an accepted request and queue its expected result
    function void note_request(req_t r);
      rsp_t e;
      int c;
      int unsigned pg, cnt;
      e = '0;
      e.status = ST_NONE;
      c = size_to_class(r.request_size);
      if (c < 0) begin
        e.status = ST_RANGE;
      end else if (r.req_type == REQ_PUSH) begin
        e.status = push_slot(c, r.free_value);
      end else begin
        for (int i = c; i < cls_used; i++) begin
          pg = last_pg[i];
          if (pg == 0) continue;
          cnt = pg_cnt[pg];
          if (cnt == 0 || cnt > EPP) continue;
          e.popped_value = slot_mem[pg * EPP + cnt - 1];
          slot_mem[pg * EPP + cnt - 1] = '0;
          e.granted_size = 35'd1 << (i + LOG2_OFF);
          pg_cnt[pg] = cnt - 1;
          if (cnt == 1) last_pg[i] = pg_prev[pg];
          e.status = ST_POPPED;
          break;
        end
      end
      pending_rsp.push_back(e);
    endfunction

    // Compare one result against the oldest expectation
    function void check_result(rsp_t a);
      rsp_t e;
      if (pending_rsp.size() == 0) begin
        $error("unexpected result status=%0d", a.status);
        errors++;
        return;
      end
      e = pending_rsp.pop_front();
      if (a.status !== e.status) begin
        $error("status: expected %0d actual %0d", e.status, a.status);
        errors++;
      end
      if (a.granted_size !== e.granted_size) begin
        $error("granted_size: expected %0h actual %0h", e.granted_size, a.granted_size);
        errors++;
      end
      if (a.popped_value !== e.popped_value) begin
        $error("popped_value: expected %0h actual %0h", e.popped_value, a.popped_value);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  logic req_valid;
  logic req_ready;
  req_t req;
  logic rsp_valid;
  logic rsp_ready;
  rsp_t rsp;

  alloc_scoreboard sb;
  bit idle_on;
  bit hold_rsp;
  longint cycle_cnt;

  segregated_free_list_allocator u_dut (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req(req),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp(rsp)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Abort on a hung run
  initial begin
    cycle_cnt = 0;
    forever begin
      @(posedge clk);
      cycle_cnt++;
      if (cycle_cnt > CYCLE_LIMIT) begin
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  // Sample results at the edge
  always @(posedge clk) begin
    if (!rst && rsp_valid && rsp_ready) sb.check_result(rsp);
  end

  // Receiver: random stall bursts, plus a long hold-off when asked
  initial begin
    int gap;
    rsp_ready = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_rsp) begin
        rsp_ready <= 1'b0;
        repeat (300) @(posedge clk);
        hold_rsp = 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        gap = $urandom_range(1, 13);
        rsp_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end else begin
        rsp_ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // Offer one request and hold it until accepted
  task automatic send_req(logic kind, logic [31:0] size, logic [39:0] val);
    req_t r;
    if (idle_on && $urandom_range(0, 4) == 0) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    r.req_type = kind;
    r.request_size = size;
    r.free_value = val;
    req_valid <= 1'b1;
    req <= r;
    do @(posedge clk); while (!req_ready);
    sb.note_request(r);
  endtask

  function automatic logic [31:0] size_of_class(int c);
    logic [31:0] base;
    base = 32'd1 << (c + LOG2_OFF);
    return base | ({$urandom} & (base - 1));
  endfunction

  function automatic logic [39:0] rand_val();
    return {8'($urandom_range(0, 255)), $urandom};
  endfunction

  initial begin
    int c;
    sb = new();
    sb.clear();
    idle_on = 1'b0;
    hold_rsp = 1'b0;
    rst = 1'b1;
    req_valid = 1'b0;
    req = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: range edges, empty pop, extremes of values
    send_req(REQ_POP, 32'd8, '0);
    send_req(REQ_PUSH, 32'd0, 40'hFF_FFFF_FFFF);
    send_req(REQ_POP, 32'd0, '0);
    send_req(REQ_PUSH, 32'd7, 40'h1);
    send_req(REQ_POP, 32'd1, '0);
    send_req(REQ_PUSH, 32'd8, 40'hFF_FFFF_FFFF);
    send_req(REQ_PUSH, 32'd15, 40'h0);
    send_req(REQ_PUSH, 32'hFFFF_FFFF, 40'hAA_5555_AAAA);
    send_req(REQ_PUSH, 32'h8000_0000, 40'h55_AAAA_5555);
    send_req(REQ_POP, 32'hFFFF_FFFF, '0);
    send_req(REQ_POP, 32'd9, '0);
    send_req(REQ_POP, 32'd8, '0);
    send_req(REQ_POP, 32'd8, '0);
    send_req(REQ_POP, 32'd8, '0);
    send_req(REQ_POP, 32'd16, '0);

    // Fill class 1 past a page, drain it, refill to reuse the chained page
    for (int i = 0; i < 66; i++) send_req(REQ_PUSH, 32'd16, rand_val());
    for (int i = 0; i < 67; i++) send_req(REQ_POP, 32'd16, '0);
    for (int i = 0; i < 66; i++) send_req(REQ_PUSH, 32'd16, rand_val());

    // Random traffic with stalls, including a long receiver hold-off
    idle_on = 1'b1;
    hold_rsp = 1'b1;
    for (int i = 0; i < 450; i++) begin
      c = $urandom_range(0, 9) < 8 ? $urandom_range(0, 5) : $urandom_range(0, 31);
      case ($urandom_range(0, 19))
        0: send_req(1'($urandom_range(0, 1)), $urandom_range(0, 7), rand_val());
        1, 2, 3, 4, 5, 6, 7, 8, 9: send_req(REQ_PUSH, size_of_class(c), rand_val());
        default: send_req(REQ_POP, size_of_class(c), rand_val());
      endcase
    end
    // Back-to-back pushes spread across classes, then pops
    idle_on = 1'b0;
    for (int i = 0; i < 120; i++) begin
      send_req(REQ_PUSH, size_of_class($urandom_range(0, 31)), rand_val());
      if (i % 4 == 0) send_req(REQ_PUSH, size_of_class($urandom_range(0, 31)), rand_val());
    end
    for (int i = 0; i < 40; i++) send_req(REQ_POP, size_of_class($urandom_range(0, 31)), '0);
    req_valid <= 1'b0;

    while (sb.pending_rsp.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (sb.errors == 0 && sb.pending_rsp.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
